// ----- hw/rtl/owtsm_pkg.sv -----
// owtsm_pkg: shared types, phase codes, action codes and bus timing constants
// for the one-wire temperature sensor master; no dependencies
package owtsm_pkg;

    // action codes of an input transaction
    localparam logic [2:0] ACT_TICK  = 3'd0;
    localparam logic [2:0] ACT_RESET = 3'd1;
    localparam logic [2:0] ACT_WRITE = 3'd2;
    localparam logic [2:0] ACT_READ  = 3'd3;
    localparam logic [2:0] ACT_TEMP  = 3'd4;

    // bus phases
    localparam logic [3:0] PH_IDLE       = 4'd0;
    localparam logic [3:0] PH_RST_PRE    = 4'd1;
    localparam logic [3:0] PH_RST_LOW    = 4'd2;
    localparam logic [3:0] PH_RST_REL    = 4'd3;
    localparam logic [3:0] PH_RST_SAMPLE = 4'd4;
    localparam logic [3:0] PH_RST_HOLD   = 4'd5;
    localparam logic [3:0] PH_GAP        = 4'd6;
    localparam logic [3:0] PH_WR_LOW     = 4'd7;
    localparam logic [3:0] PH_WR_BIT     = 4'd8;
    localparam logic [3:0] PH_WR_REC     = 4'd9;
    localparam logic [3:0] PH_RD_PRE     = 4'd10;
    localparam logic [3:0] PH_RD_LOW     = 4'd11;
    localparam logic [3:0] PH_RD_REL     = 4'd12;
    localparam logic [3:0] PH_RD_TAIL    = 4'd13;

    // steps of the temperature read sequence; the steps after these read bytes
    localparam logic [3:0] SEQ_RESET_A = 4'd0;
    localparam logic [3:0] SEQ_GAP_A   = 4'd1;
    localparam logic [3:0] SEQ_SKIP_A  = 4'd2;
    localparam logic [3:0] SEQ_CONVERT = 4'd3;
    localparam logic [3:0] SEQ_RESET_B = 4'd4;
    localparam logic [3:0] SEQ_GAP_B   = 4'd5;
    localparam logic [3:0] SEQ_SKIP_B  = 4'd6;
    localparam logic [3:0] SEQ_READ_SP = 4'd7;

    // durations in microseconds
    localparam logic [8:0] US_RST_PRE  = 9'd50;
    localparam logic [8:0] US_RST_LOW  = 9'd500;
    localparam logic [8:0] US_RST_REL  = 9'd40;
    localparam logic [8:0] US_RST_WIN  = 9'd51;
    localparam logic [8:0] US_RST_HOLD = 9'd500;
    localparam logic [8:0] US_GAP      = 9'd100;
    localparam logic [8:0] US_WR_LOW   = 9'd6;
    localparam logic [8:0] US_WR_BIT   = 9'd65;
    localparam logic [8:0] US_WR_REC   = 9'd3;
    localparam logic [8:0] US_RD_PRE   = 9'd5;
    localparam logic [8:0] US_RD_LOW   = 9'd6;
    localparam logic [8:0] US_RD_REL   = 9'd6;
    localparam logic [8:0] US_RD_TAIL  = 9'd65;

    // device command bytes
    localparam logic [7:0] OW_SKIP_ROM = 8'hCC;
    localparam logic [7:0] OW_CONVERT  = 8'h44;
    localparam logic [7:0] OW_READ_SP  = 8'hBE;

    localparam logic [3:0] BITS_PER_BYTE = 4'd8;
    localparam logic [3:0] SEQ_LAST      = 4'd9;
    localparam logic [7:0] TPU_RESET     = 8'd1;

    typedef struct packed {
        logic [2:0] action;
        logic [7:0] data_byte;
        logic       line_level;
    } t_item;

    typedef struct packed {
        logic        drive_low;
        logic        busy_res;
        logic        done_res;
        logic        presence;
        logic [15:0] read_value;
    } t_result;

    typedef struct packed {
        logic [3:0]  phase;
        logic [8:0]  us_cnt;
        logic [7:0]  presc;
        logic [3:0]  bit_idx;
        logic [7:0]  tx;
        logic [15:0] rx;
        logic [3:0]  seq;
        logic [2:0]  cmd;
        logic        presence;
        logic        drive;
    } t_state;

endpackage

// ----- hw/rtl/owtsm_if.sv -----
// owtsm_in_if / owtsm_out_if: valid-ready channels of the one-wire master
// depends on nothing
interface owtsm_in_if;
    logic       valid;
    logic       ready;
    logic [2:0] action;
    logic [7:0] data_byte;
    logic       line_level;

    modport source(output valid, action, data_byte, line_level, input ready);
    modport sink(input valid, action, data_byte, line_level, output ready);
endinterface

interface owtsm_out_if;
    logic        valid;
    logic        ready;
    logic        drive_low;
    logic        busy_res;
    logic        done_res;
    logic        presence;
    logic [15:0] read_value;

    modport source(output valid, drive_low, busy_res, done_res, presence, read_value,
                   input ready);
    modport sink(input valid, drive_low, busy_res, done_res, presence, read_value,
                 output ready);
endinterface

// ----- hw/rtl/owtsm_step.sv -----
// owtsm_step: next-state and result logic for one transaction of the master
// depends on owtsm_pkg
module owtsm_step (
    input  owtsm_pkg::t_state  i_state,
    input  owtsm_pkg::t_item   i_item,
    input  logic [7:0]         i_tpu,
    output owtsm_pkg::t_state  o_state,
    output owtsm_pkg::t_result o_res
);

    function automatic owtsm_pkg::t_state f_enter(owtsm_pkg::t_state s, logic [3:0] ph,
                                                  logic [8:0] n, logic low);
        owtsm_pkg::t_state r;
        r        = s;
        r.phase  = ph;
        r.us_cnt = n;
        r.drive  = low;
        return r;
    endfunction

    function automatic owtsm_pkg::t_state f_begin_write(owtsm_pkg::t_state s,
                                                        logic [7:0] b);
        owtsm_pkg::t_state r;
        r         = s;
        r.tx      = b;
        r.bit_idx = '0;
        return f_enter(r, owtsm_pkg::PH_WR_LOW, owtsm_pkg::US_WR_LOW, 1'b1);
    endfunction

    function automatic owtsm_pkg::t_state f_begin_read(owtsm_pkg::t_state s);
        owtsm_pkg::t_state r;
        r         = s;
        r.bit_idx = '0;
        return f_enter(r, owtsm_pkg::PH_RD_PRE, owtsm_pkg::US_RD_PRE, 1'b0);
    endfunction

    function automatic owtsm_pkg::t_state f_begin_reset(owtsm_pkg::t_state s);
        return f_enter(s, owtsm_pkg::PH_RST_PRE, owtsm_pkg::US_RST_PRE, 1'b0);
    endfunction

    // temperature read sequence: reset, gap, skip, convert, reset, gap, skip, read, 2 bytes
    function automatic owtsm_pkg::t_state f_begin_step(owtsm_pkg::t_state s);
        owtsm_pkg::t_state r;
        case (s.seq) inside
            owtsm_pkg::SEQ_RESET_A, owtsm_pkg::SEQ_RESET_B:
                r = f_begin_reset(s);
            owtsm_pkg::SEQ_GAP_A, owtsm_pkg::SEQ_GAP_B:
                r = f_enter(s, owtsm_pkg::PH_GAP, owtsm_pkg::US_GAP, 1'b0);
            owtsm_pkg::SEQ_SKIP_A, owtsm_pkg::SEQ_SKIP_B:
                r = f_begin_write(s, owtsm_pkg::OW_SKIP_ROM);
            owtsm_pkg::SEQ_CONVERT:
                r = f_begin_write(s, owtsm_pkg::OW_CONVERT);
            owtsm_pkg::SEQ_READ_SP:
                r = f_begin_write(s, owtsm_pkg::OW_READ_SP);
            default:
                r = f_begin_read(s);
        endcase
        return r;
    endfunction

    function automatic logic f_last_sub(owtsm_pkg::t_state s);
        return !(s.cmd == owtsm_pkg::ACT_TEMP && s.seq < owtsm_pkg::SEQ_LAST);
    endfunction

    function automatic owtsm_pkg::t_state f_end_sub(owtsm_pkg::t_state s);
        owtsm_pkg::t_state r;
        r = s;
        if (!f_last_sub(s)) begin
            r.seq = s.seq + 4'd1;
            r     = f_begin_step(r);
        end else begin
            r.phase = owtsm_pkg::PH_IDLE;
            r.drive = 1'b0;
        end
        return r;
    endfunction

    owtsm_pkg::t_state s;
    logic [7:0]        limit;
    logic [8:0]        presc_inc;
    logic [8:0]        cnt_dec;
    logic              is_cmd;
    logic              done;

    assign limit     = (i_tpu == 8'd0) ? 8'd1 : i_tpu;
    assign presc_inc = {1'b0, i_state.presc} + 9'd1;
    assign cnt_dec   = (i_state.us_cnt != 9'd0) ? (i_state.us_cnt - 9'd1) : 9'd0;

    always_comb begin
        case (i_item.action) inside
            owtsm_pkg::ACT_RESET, owtsm_pkg::ACT_WRITE,
            owtsm_pkg::ACT_READ, owtsm_pkg::ACT_TEMP: is_cmd = 1'b1;
            default:                                  is_cmd = 1'b0;
        endcase
    end

    always_comb begin
        s    = i_state;
        done = 1'b0;
        if (i_state.phase == owtsm_pkg::PH_IDLE) begin
            if (is_cmd) begin
                s.cmd   = i_item.action;
                s.presc = '0;
                s.rx    = '0;
                s.seq   = owtsm_pkg::SEQ_RESET_A;
                case (i_item.action)
                    owtsm_pkg::ACT_RESET: s = f_begin_reset(s);
                    owtsm_pkg::ACT_WRITE: s = f_begin_write(s, i_item.data_byte);
                    owtsm_pkg::ACT_READ:  s = f_begin_read(s);
                    default:              s = f_begin_step(s);
                endcase
            end
        end else if (!is_cmd) begin
            if (presc_inc >= {1'b0, limit}) begin
                // one microsecond elapsed
                s.presc  = '0;
                s.us_cnt = cnt_dec;
                if (i_state.phase == owtsm_pkg::PH_RST_SAMPLE) begin
                    if (!i_item.line_level) begin
                        s.presence = 1'b1;
                        s = f_enter(s, owtsm_pkg::PH_RST_HOLD, owtsm_pkg::US_RST_HOLD, 1'b0);
                    end else if (cnt_dec == 9'd0) begin
                        s.presence = 1'b0;
                        done       = f_last_sub(s);
                        s          = f_end_sub(s);
                    end
                end else if (cnt_dec == 9'd0) begin
                    unique case (i_state.phase)
                        owtsm_pkg::PH_RST_PRE:
                            s = f_enter(s, owtsm_pkg::PH_RST_LOW, owtsm_pkg::US_RST_LOW, 1'b1);
                        owtsm_pkg::PH_RST_LOW:
                            s = f_enter(s, owtsm_pkg::PH_RST_REL, owtsm_pkg::US_RST_REL, 1'b0);
                        owtsm_pkg::PH_RST_REL:
                            s = f_enter(s, owtsm_pkg::PH_RST_SAMPLE, owtsm_pkg::US_RST_WIN,
                                        1'b0);
                        owtsm_pkg::PH_RST_HOLD, owtsm_pkg::PH_GAP: begin
                            done = f_last_sub(s);
                            s    = f_end_sub(s);
                        end
                        owtsm_pkg::PH_WR_LOW:
                            s = f_enter(s, owtsm_pkg::PH_WR_BIT, owtsm_pkg::US_WR_BIT,
                                        ~i_state.tx[0]);
                        owtsm_pkg::PH_WR_BIT:
                            s = f_enter(s, owtsm_pkg::PH_WR_REC, owtsm_pkg::US_WR_REC, 1'b0);
                        owtsm_pkg::PH_WR_REC: begin
                            s.tx      = {1'b0, i_state.tx[7:1]};
                            s.bit_idx = i_state.bit_idx + 4'd1;
                            if (s.bit_idx >= owtsm_pkg::BITS_PER_BYTE) begin
                                done = f_last_sub(s);
                                s    = f_end_sub(s);
                            end else begin
                                s = f_enter(s, owtsm_pkg::PH_WR_LOW, owtsm_pkg::US_WR_LOW,
                                            1'b1);
                            end
                        end
                        owtsm_pkg::PH_RD_PRE:
                            s = f_enter(s, owtsm_pkg::PH_RD_LOW, owtsm_pkg::US_RD_LOW, 1'b1);
                        owtsm_pkg::PH_RD_LOW:
                            s = f_enter(s, owtsm_pkg::PH_RD_REL, owtsm_pkg::US_RD_REL, 1'b0);
                        owtsm_pkg::PH_RD_REL: begin
                            s.rx = {i_item.line_level, i_state.rx[15:1]};
                            s    = f_enter(s, owtsm_pkg::PH_RD_TAIL, owtsm_pkg::US_RD_TAIL,
                                           1'b0);
                        end
                        owtsm_pkg::PH_RD_TAIL: begin
                            s.bit_idx = i_state.bit_idx + 4'd1;
                            if (s.bit_idx >= owtsm_pkg::BITS_PER_BYTE) begin
                                done = f_last_sub(s);
                                s    = f_end_sub(s);
                            end else begin
                                s = f_enter(s, owtsm_pkg::PH_RD_PRE, owtsm_pkg::US_RD_PRE,
                                            1'b0);
                            end
                        end
                        default: begin
                            s.phase = owtsm_pkg::PH_IDLE;
                            s.drive = 1'b0;
                        end
                    endcase
                end
            end else begin
                s.presc = presc_inc[7:0];
            end
        end
    end

    assign o_state = s;

    always_comb begin
        o_res.drive_low  = s.drive;
        o_res.busy_res   = (s.phase != owtsm_pkg::PH_IDLE);
        o_res.done_res   = done;
        o_res.presence   = s.presence;
        o_res.read_value = '0;
        if (done) begin
            if (s.cmd == owtsm_pkg::ACT_READ) begin
                o_res.read_value = {8'h00, s.rx[15:8]};
            end else if (s.cmd == owtsm_pkg::ACT_TEMP) begin
                o_res.read_value = s.rx;
            end
        end
    end

endmodule

// ----- hw/rtl/one_wire_temp_sensor_master.sv -----
// one_wire_temp_sensor_master: top level of the one-wire bus master
// depends on owtsm_pkg, owtsm_if (channels) and owtsm_step
//
//  channel | dir | payload                                        | transaction when
//  --------+-----+------------------------------------------------+------------------------
//  i_in    | in  | action, data_byte, line_level                  | valid && ready
//  o_out   | out | drive_low, busy_res, done_res, presence,       | valid && ready
//          |     | read_value                                     |
//  i_cfg_* | in  | ticks_per_us (i_cfg_wdata)                     | i_cfg_we
//
// one transaction per clock cycle sustained while the output side is ready
// the input register feeds the step logic, whose result goes to the output register
// the bus state updates in the same cycle the output register loads
// a stalled output holds the result; the input side keeps accepting while a slot is free
// reset (synchronous, active low) sets the bus idle, released, ticks_per_us to 1
module one_wire_temp_sensor_master (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [7:0]        i_cfg_wdata,
    owtsm_in_if.sink          i_in,
    owtsm_out_if.source       o_out
);

    // input stage
    logic                 r_in_valid;
    owtsm_pkg::t_item     r_in;

    // bus state and configuration
    owtsm_pkg::t_state    r_state;
    owtsm_pkg::t_state    n_state;
    logic [7:0]           r_tpu;

    // output stage
    logic                 r_out_valid;
    owtsm_pkg::t_result   r_res;
    owtsm_pkg::t_result   n_res;

    logic                 advance;

    // the stored item is processed once the output register can take its result
    assign advance    = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || advance;

    owtsm_step u_step (
        .i_state (r_state),
        .i_item  (r_in),
        .i_tpu   (r_tpu),
        .o_state (n_state),
        .o_res   (n_res)
    );

    // control and bus state; all-zero state is idle with the line released
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid       <= 1'b0;
            r_out_valid      <= 1'b0;
            r_tpu            <= owtsm_pkg::TPU_RESET;
            r_state          <= '0;
        end else begin
            if (i_cfg_we) begin
                r_tpu <= i_cfg_wdata;
            end
            if (i_in.ready) begin
                r_in_valid <= i_in.valid;
            end
            if (advance) begin
                r_state     <= n_state;
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in.action     <= i_in.action;
            r_in.data_byte  <= i_in.data_byte;
            r_in.line_level <= i_in.line_level;
        end
        if (advance) begin
            r_res <= n_res;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.drive_low  = r_res.drive_low;
    assign o_out.busy_res   = r_res.busy_res;
    assign o_out.done_res   = r_res.done_res;
    assign o_out.presence   = r_res.presence;
    assign o_out.read_value = r_res.read_value;

`ifndef SYNTHESIS
    // a finished command leaves the bus idle
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.done_res |-> !o_out.busy_res)
        else $error("done reported while still busy");

    // the line is only pulled low during a command
    a_idle_released: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.busy_res |-> !o_out.drive_low)
        else $error("line driven low while idle");

    // read data appears only on the finishing transaction
    a_value_on_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.done_res |-> o_out.read_value == 16'd0)
        else $error("read value outside done");

    // bus state moves only when a transaction is processed
    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !advance |=> $stable(r_state))
        else $error("bus state changed without a transaction");
`endif

endmodule
